### hdl/kclc_pkg.sv
// ----------------------------------------------------------------------------
// kclc_pkg
// Shared types and constants of the keypad code lock controller.
// ----------------------------------------------------------------------------
package kclc_pkg;

  // Keypad sample: bits 0..8 are keys 1..9, then star, zero, hash
  localparam int unsigned KEY_W = 12;
  localparam logic [KEY_W-1:0] KEY_ONE   = 12'd1;
  localparam logic [KEY_W-1:0] KEY_TWO   = 12'd2;
  localparam logic [KEY_W-1:0] KEY_THREE = 12'd4;
  localparam logic [KEY_W-1:0] KEY_FOUR  = 12'd8;
  localparam logic [KEY_W-1:0] KEY_STAR  = 12'd512;
  localparam logic [KEY_W-1:0] KEY_ZERO  = 12'd1024;
  localparam logic [KEY_W-1:0] KEY_HASH  = 12'd2048;

  localparam int unsigned FAIL_W  = 4;
  localparam int unsigned TIMER_W = 16;
  localparam int unsigned MODE_W  = 3;
  localparam int unsigned EV_W    = 4;
  localparam int unsigned SCROLL_W = 2;
  localparam int unsigned DIGOUT_W = 3;

  localparam logic [FAIL_W-1:0] FAIL_MAX = 4'd15;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_FAIL_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCKOUT    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_HOLD  = 2'd2;

  localparam logic [FAIL_W-1:0]  RST_FAIL_LIMIT = 4'd3;
  localparam logic [TIMER_W-1:0] RST_LOCKOUT    = 16'd10000;
  localparam logic [TIMER_W-1:0] RST_OPEN_HOLD  = 16'd2000;

  typedef enum logic [MODE_W-1:0] {
    MODE_MENU    = 3'd0,
    MODE_ENTER   = 3'd1,
    MODE_SET     = 3'd2,
    MODE_OLD     = 3'd3,
    MODE_NEW     = 3'd4,
    MODE_OPEN    = 3'd5,
    MODE_LOCKOUT = 3'd6
  } mode_e;

  typedef enum logic [EV_W-1:0] {
    EV_NONE     = 4'd0,
    EV_BEEP     = 4'd1,
    EV_OPENED   = 4'd2,
    EV_WRONG    = 4'd3,
    EV_LOCKOUT  = 4'd4,
    EV_SET_DONE = 4'd5,
    EV_CHANGED  = 4'd6,
    EV_REFUSED  = 4'd7,
    EV_CLOSED   = 4'd8
  } event_e;

  typedef struct packed {
    logic [FAIL_W-1:0]  fail_limit;
    logic [TIMER_W-1:0] lockout_ticks;
    logic [TIMER_W-1:0] open_hold_ticks;
  } cfg_t;

  // Scalar lock state (code storage and digit count travel separately)
  typedef struct packed {
    mode_e               mode;
    logic [KEY_W-1:0]    prev_keys;
    logic                old_match;
    logic [FAIL_W-1:0]   wrong;
    logic                mute;
    logic [SCROLL_W-1:0] scroll;
    logic [TIMER_W-1:0]  timer;
  } lock_state_t;

  typedef struct packed {
    logic                servo_on;
    logic [MODE_W-1:0]   mode;
    logic [DIGOUT_W-1:0] digits;
    logic [FAIL_W-1:0]   fail_count;
    logic                muted;
    logic [SCROLL_W-1:0] menu_pos;
    logic [EV_W-1:0]     event_res;
  } result_t;

endpackage

### hdl/kclc_cfg.sv
// ----------------------------------------------------------------------------
// kclc_cfg
// Configuration registers: write-only, decoded by register index.
// ----------------------------------------------------------------------------
module kclc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kclc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output kclc_pkg::cfg_t                     cfg_o
);
  import kclc_pkg::*;

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FAIL_LIMIT: cfg_d.fail_limit      = cfg_data_i[FAIL_W-1:0];
        CFG_LOCKOUT:    cfg_d.lockout_ticks   = cfg_data_i[TIMER_W-1:0];
        CFG_OPEN_HOLD:  cfg_d.open_hold_ticks = cfg_data_i[TIMER_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fail_limit      <= RST_FAIL_LIMIT;
      cfg_q.lockout_ticks   <= RST_LOCKOUT;
      cfg_q.open_hold_ticks <= RST_OPEN_HOLD;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/kclc_step.sv
// ----------------------------------------------------------------------------
// kclc_step
// Single-pass next-state and result logic for one keypad sample or tick.
// ----------------------------------------------------------------------------
module kclc_step #(
  parameter int unsigned CODE_DIGITS = 4,
  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1),
  localparam int unsigned IDX_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1
) (
  input  kclc_pkg::cfg_t                                      cfg_i,
  input  kclc_pkg::lock_state_t                               st_i,
  input  logic [CNT_W-1:0]                                    cnt_i,
  input  logic [CODE_DIGITS-1:0][kclc_pkg::KEY_W-1:0]         code_i,
  input  logic [CODE_DIGITS-1:0][kclc_pkg::KEY_W-1:0]         buf_i,
  input  logic                                                action_i,
  input  logic [kclc_pkg::KEY_W-1:0]                          keys_i,
  output kclc_pkg::lock_state_t                               st_o,
  output logic [CNT_W-1:0]                                    cnt_o,
  output logic [CODE_DIGITS-1:0][kclc_pkg::KEY_W-1:0]         code_o,
  output logic [CODE_DIGITS-1:0][kclc_pkg::KEY_W-1:0]         buf_o,
  output kclc_pkg::result_t                                   res_o
);
  import kclc_pkg::*;

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CODE_DIGITS);

  logic                                  busy, press, tmr_done;
  logic                                  is_star, is_hash, room, full;
  logic                                  take_digit, chg_digit, hash_full, last_digit;
  logic                                  eq_old, eq_new, lock_trip;
  logic [CNT_W-1:0]                      cnt_inc;
  logic [IDX_W-1:0]                      wr_idx;
  logic [FAIL_W-1:0]                     wrong_inc;
  logic [CODE_DIGITS-1:0][KEY_W-1:0]     buf_new;
  mode_e                                 mode_d;
  logic [3:0]                            cnt_ext;

  // Decode the item against the current state
  assign busy      = (st_i.mode == MODE_OPEN) || (st_i.mode == MODE_LOCKOUT);
  assign press     = !action_i && (keys_i != '0) && (st_i.prev_keys == '0) && !busy;
  assign tmr_done  = st_i.timer <= TIMER_W'(1);
  assign is_star   = keys_i == KEY_STAR;
  assign is_hash   = keys_i == KEY_HASH;
  assign room      = cnt_i < CNT_FULL;
  assign full      = cnt_i == CNT_FULL;
  assign cnt_inc   = cnt_i + CNT_W'(1);
  assign wr_idx    = cnt_i[IDX_W-1:0];
  assign take_digit = !is_star && room;
  assign chg_digit  = !is_star && !is_hash && room;
  assign hash_full  = is_hash && full;
  assign last_digit = cnt_inc == CNT_FULL;
  assign wrong_inc  = (st_i.wrong == FAIL_MAX) ? st_i.wrong : st_i.wrong + FAIL_W'(1);
  assign lock_trip  = wrong_inc >= cfg_i.fail_limit;

  always_comb begin
    for (int i = 0; i < CODE_DIGITS; i++) begin
      buf_new[i] = (IDX_W'(i) == wr_idx) ? keys_i : buf_i[i];
    end
  end

  assign eq_old = code_i == buf_i;
  assign eq_new = code_i == buf_new;

  // Next mode
  always_comb begin
    mode_d = st_i.mode;
    if (action_i) begin
      if (busy && tmr_done) begin
        mode_d = MODE_MENU;
      end
    end else if (press) begin
      unique case (st_i.mode)
        MODE_MENU: begin
          if (keys_i == KEY_ONE) begin
            mode_d = MODE_ENTER;
          end else if (keys_i == KEY_TWO) begin
            mode_d = MODE_SET;
          end else if (keys_i == KEY_THREE) begin
            mode_d = MODE_OLD;
          end
        end
        MODE_ENTER: begin
          if (!take_digit && hash_full) begin
            if (eq_old) begin
              mode_d = MODE_OPEN;
            end else if (lock_trip) begin
              mode_d = MODE_LOCKOUT;
            end
          end
        end
        MODE_SET: begin
          if (hash_full) begin
            mode_d = MODE_MENU;
          end
        end
        MODE_OLD: begin
          if (chg_digit && last_digit) begin
            mode_d = MODE_NEW;
          end
        end
        MODE_NEW: begin
          if (chg_digit && last_digit) begin
            mode_d = MODE_MENU;
          end
        end
        default: ;
      endcase
    end
  end

  // Data path and event
  always_comb begin
    st_o           = st_i;
    st_o.mode      = mode_d;
    cnt_o          = cnt_i;
    code_o         = code_i;
    buf_o          = buf_i;
    res_o.event_res = EV_NONE;

    if (action_i) begin
      if (busy) begin
        if (tmr_done) begin
          st_o.timer = '0;
          if (st_i.mode == MODE_OPEN) begin
            res_o.event_res = EV_CLOSED;
          end
        end else begin
          st_o.timer = st_i.timer - TIMER_W'(1);
        end
      end
    end else begin
      st_o.prev_keys = keys_i;
      if (press) begin
        case (st_i.mode)
          MODE_MENU: begin
            res_o.event_res = EV_BEEP;
            if (is_star) begin
              st_o.scroll = st_i.scroll + SCROLL_W'(1);
            end else if (keys_i == KEY_ONE || keys_i == KEY_THREE) begin
              cnt_o = '0;
            end else if (keys_i == KEY_TWO) begin
              cnt_o  = '0;
              code_o = '0;
            end else if (keys_i == KEY_FOUR) begin
              st_o.mute = !st_i.mute;
            end
          end
          MODE_ENTER: begin
            if (take_digit) begin
              buf_o = buf_new;
              cnt_o = cnt_inc;
              res_o.event_res = EV_BEEP;
            end else if (hash_full) begin
              cnt_o = '0;
              if (eq_old) begin
                st_o.wrong = '0;
                st_o.timer = cfg_i.open_hold_ticks;
                res_o.event_res = EV_OPENED;
              end else begin
                st_o.wrong = wrong_inc;
                if (lock_trip) begin
                  st_o.timer = cfg_i.lockout_ticks;
                  res_o.event_res = EV_LOCKOUT;
                end else begin
                  res_o.event_res = EV_WRONG;
                end
              end
            end
          end
          MODE_SET: begin
            if (hash_full) begin
              cnt_o = '0;
              res_o.event_res = EV_SET_DONE;
            end else if (take_digit) begin
              for (int i = 0; i < CODE_DIGITS; i++) begin
                if (IDX_W'(i) == wr_idx) begin
                  code_o[i] = keys_i;
                end
              end
              cnt_o = cnt_inc;
              res_o.event_res = EV_BEEP;
            end
          end
          MODE_OLD, MODE_NEW: begin
            if (chg_digit) begin
              buf_o = buf_new;
              if (!last_digit) begin
                cnt_o = cnt_inc;
                res_o.event_res = EV_BEEP;
              end else begin
                cnt_o = '0;
                if (st_i.mode == MODE_OLD) begin
                  st_o.old_match = eq_new;
                  res_o.event_res = EV_BEEP;
                end else if (st_i.old_match) begin
                  code_o = buf_new;
                  res_o.event_res = EV_CHANGED;
                end else begin
                  res_o.event_res = EV_REFUSED;
                end
              end
            end
          end
          default: ;
        endcase
      end
    end

    cnt_ext          = 4'(cnt_o);
    res_o.servo_on   = mode_d == MODE_OPEN;
    res_o.mode       = mode_d;
    res_o.digits     = cnt_ext[DIGOUT_W-1:0];
    res_o.fail_count = st_o.wrong;
    res_o.muted      = st_o.mute;
    res_o.menu_pos   = st_o.scroll;
  end

endmodule

### hdl/keypad_code_lock_controller_unit.sv
// ----------------------------------------------------------------------------
// keypad_code_lock_controller_unit
// Keypad code lock: menu, code entry, code set/change, timed open and lockout.
// ----------------------------------------------------------------------------
// Path: an item is held in the input register and its result is then registered
//   in the result register.
// Throughput: one item per cycle unless out_ready_i stalls; the whole state update
//   is one combinational pass between the input register and the result register.
// Reset: rst_ni clears control state, returns to the menu, restores the
//   configuration defaults and sets every stored code digit to key zero.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller_unit #(
  parameter int unsigned CODE_DIGITS = 4
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // configuration writes
  input  logic                               cfg_we_i,
  input  logic [kclc_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [kclc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  // item channel
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic                               action_i,
  input  logic [kclc_pkg::KEY_W-1:0]         keys_i,
  // result channel
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               servo_on_o,
  output logic [kclc_pkg::MODE_W-1:0]        mode_o,
  output logic [kclc_pkg::DIGOUT_W-1:0]      digits_entered_o,
  output logic [kclc_pkg::FAIL_W-1:0]        fail_count_o,
  output logic                               muted_o,
  output logic [kclc_pkg::SCROLL_W-1:0]      menu_position_o,
  output logic [kclc_pkg::EV_W-1:0]          event_res_o
);
  import kclc_pkg::*;

  localparam int unsigned CNT_W = $clog2(CODE_DIGITS + 1);

  cfg_t cfg;

  // Input register stage
  logic             in_vld_q, in_vld_d;
  logic             action_q;
  logic [KEY_W-1:0] keys_q;
  logic             in_xfer, advance;

  // Lock state
  lock_state_t                     st_q, st_d;
  logic [CNT_W-1:0]                cnt_q, cnt_d;
  logic [CODE_DIGITS-1:0][KEY_W-1:0] code_q, code_d;
  logic [CODE_DIGITS-1:0][KEY_W-1:0] buf_q, buf_d;

  // Result register stage
  logic    out_vld_q, out_vld_d;
  result_t res_q, res_d;

  kclc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  kclc_step #(
    .CODE_DIGITS (CODE_DIGITS)
  ) u_step (
    .cfg_i    (cfg),
    .st_i     (st_q),
    .cnt_i    (cnt_q),
    .code_i   (code_q),
    .buf_i    (buf_q),
    .action_i (action_q),
    .keys_i   (keys_q),
    .st_o     (st_d),
    .cnt_o    (cnt_d),
    .code_o   (code_d),
    .buf_o    (buf_d),
    .res_o    (res_d)
  );

  // Advance the held item into the result register whenever that register is
  // empty or its result is taken in the same cycle. The lock state commits at
  // the same edge, so items update the state strictly in transfer order.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_xfer    = in_valid_i && in_ready_o;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_xfer) begin
      in_vld_d = 1'b1;
    end else if (advance) begin
      in_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '{mode: MODE_MENU, default: '0};
      cnt_q     <= '0;
      code_q    <= {CODE_DIGITS{KEY_ZERO}};
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      if (advance) begin
        st_q   <= st_d;
        cnt_q  <= cnt_d;
        code_q <= code_d;
      end
    end
  end

  // Payload: item hold, entry buffer (undefined until written) and result
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      action_q <= action_i;
      keys_q   <= keys_i;
    end
    if (advance) begin
      buf_q <= buf_d;
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign servo_on_o       = res_q.servo_on;
  assign mode_o           = res_q.mode;
  assign digits_entered_o = res_q.digits;
  assign fail_count_o     = res_q.fail_count;
  assign muted_o          = res_q.muted;
  assign menu_position_o  = res_q.menu_pos;
  assign event_res_o      = res_q.event_res;

  // The door drive follows the open mode exactly
  a_door_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (servo_on_o == (mode_o == MODE_OPEN)))
    else $error("door drive disagrees with mode");

  // An opened event always lands in the open mode with a cleared fail count
  a_opened: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_OPENED) |->
      (mode_o == MODE_OPEN && fail_count_o == '0))
    else $error("opened event without open mode");

  // A lockout event means lockout mode with at least one recorded failure
  a_lockout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_LOCKOUT) |->
      (mode_o == MODE_LOCKOUT && fail_count_o != '0))
    else $error("lockout event inconsistent");

  // Closing returns to the menu
  a_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && event_res_o == EV_CLOSED) |-> (mode_o == MODE_MENU))
    else $error("closed event outside menu");

  // A held item that cannot advance stays in the input register
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> in_vld_q)
    else $error("stalled item lost from input register");

endmodule
